@@ sv/rgcd_pkg.sv @@
// shared types, constants and address helpers for the rle glyph column decoder
// no dependencies
package rgcd_pkg;

  localparam int LINE_WIDTH  = 320;
  localparam int GLYPH_WIDTH = 8;
  localparam int MAX_ROWS    = 8;
  localparam int ADDR_W      = 12;
  localparam int ROWS_W      = 4;
  localparam int SIZE_W      = $clog2(LINE_WIDTH * MAX_ROWS + 1);
  localparam int POS_W       = (SIZE_W > ADDR_W) ? SIZE_W : ADDR_W;
  localparam int X_W         = $clog2(LINE_WIDTH);
  localparam int LINES_MAX   = ((1 << ADDR_W) / LINE_WIDTH > MAX_ROWS) ?
                               (1 << ADDR_W) / LINE_WIDTH : MAX_ROWS;
  localparam int LINE_W      = $clog2(LINES_MAX + 1);
  localparam int RUN_W       = 7;
  localparam int CTRL_RUN    = 128;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_RUN     = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef enum logic {
    REG_GLYPH_ROWS     = 1'b0,
    REG_START_POSITION = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address_a;
    logic [7:0]        value_a;
    logic [ADDR_W-1:0] address_b;
    logic [7:0]        value_b;
    logic [1:0]        pixel_count;
    logic              last;
    logic              done_res;
  } out_item_t;

  typedef struct packed {
    logic             restart;
    logic [7:0]       value;
    logic [RUN_W-1:0] npix;
    logic             done;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        col;
    logic [X_W-1:0]    x;
    logic [LINE_W-1:0] line;
  } pix_pos_t;

  function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] rows);
    logic [ROWS_W-1:0] r;
    r = rows;
    if (rows == '0) r = ROWS_W'(1);
    else if (rows > ROWS_W'(MAX_ROWS)) r = ROWS_W'(MAX_ROWS);
    return r;
  endfunction

  function automatic logic [POS_W-1:0] strip_size(input logic [ROWS_W-1:0] rows);
    return POS_W'(LINE_WIDTH * int'(eff_rows(rows)));
  endfunction

  function automatic pix_pos_t pos_split(input logic [ADDR_W-1:0] start);
    pix_pos_t p;
    logic [LINE_W-1:0] ln;
    logic [ADDR_W-1:0] base;
    ln = '0;
    for (int k = 1; k <= LINES_MAX; k++) begin
      if (int'(start) >= k * LINE_WIDTH) ln = LINE_W'(k);
    end
    base   = ADDR_W'(int'(ln) * LINE_WIDTH);
    p.col  = start[2:0];
    p.x    = X_W'(start - base);
    p.line = ln;
    return p;
  endfunction

  function automatic pix_pos_t pos_inc(input pix_pos_t p);
    pix_pos_t q;
    q.col = p.col + 3'd1;
    if (p.x == X_W'(LINE_WIDTH - 1)) begin
      q.x    = '0;
      q.line = p.line + LINE_W'(1);
    end else begin
      q.x    = p.x + X_W'(1);
      q.line = p.line;
    end
    return q;
  endfunction

  function automatic logic [ADDR_W-1:0] glyph_addr(input pix_pos_t p,
                                                   input logic [ROWS_W-1:0] rows);
    logic [ADDR_W-1:0] gx;
    logic [ADDR_W-1:0] gr;
    gx = ADDR_W'(p.x >> 3);
    gr = ADDR_W'(gx * ADDR_W'(eff_rows(rows)));
    return ADDR_W'(p.col) + (ADDR_W'(p.line) << 3) + (gr << 3);
  endfunction

endpackage

@@ sv/rgcd_front.sv @@
// front end: parses control, run and literal bytes and tracks the strip position
// depends on rgcd_pkg
module rgcd_front import rgcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  in_item_t          item,
  input  logic [ROWS_W-1:0] glyph_rows,
  input  logic [ADDR_W-1:0] start_position,
  output cmd_t              cmd
);

  phase_t           phase, phase_next;
  logic [RUN_W-1:0] remaining, remaining_next;
  logic [POS_W-1:0] position, position_next;
  logic             finished, finished_next;

  phase_t           ph_e;
  logic [RUN_W-1:0] rem_e;
  logic [POS_W-1:0] pos_e;
  logic             fin_e;
  logic [POS_W-1:0] strip;
  logic [POS_W-1:0] avail;
  logic             run_clip;
  logic [RUN_W-1:0] run_w;
  logic             lit_end;

  always_comb begin
    strip = strip_size(glyph_rows);
    if (item.first_byte) begin
      ph_e  = PH_CONTROL;
      rem_e = '0;
      pos_e = POS_W'(start_position);
      fin_e = (POS_W'(start_position) >= strip);
    end else begin
      ph_e  = phase;
      rem_e = remaining;
      pos_e = position;
      fin_e = finished;
    end
    avail    = strip - pos_e;
    run_clip = (POS_W'(rem_e) >= avail);
    run_w    = run_clip ? RUN_W'(avail) : rem_e;
    lit_end  = ((pos_e + POS_W'(1)) >= strip);
  end

  always_comb begin
    phase_next     = ph_e;
    remaining_next = rem_e;
    position_next  = pos_e;
    finished_next  = fin_e;
    if (!fin_e) begin
      unique case (ph_e)
        PH_CONTROL: begin
          if (item.code_byte == 8'd0) begin
            finished_next = 1'b1;
          end else if (item.code_byte >= 8'(CTRL_RUN)) begin
            phase_next     = PH_RUN;
            remaining_next = item.code_byte[RUN_W-1:0];
          end else begin
            phase_next     = PH_LITERAL;
            remaining_next = item.code_byte[RUN_W-1:0];
          end
        end
        PH_RUN: begin
          phase_next     = PH_CONTROL;
          remaining_next = '0;
          position_next  = pos_e + POS_W'(run_w);
          finished_next  = run_clip;
        end
        PH_LITERAL: begin
          position_next = pos_e + POS_W'(1);
          if (lit_end) begin
            finished_next  = 1'b1;
            phase_next     = PH_CONTROL;
            remaining_next = '0;
          end else begin
            remaining_next = rem_e - RUN_W'(1);
            if (rem_e == RUN_W'(1)) phase_next = PH_CONTROL;
          end
        end
        default: begin
          phase_next = PH_CONTROL;
        end
      endcase
    end
  end

  always_comb begin
    cmd.restart = item.first_byte;
    cmd.value   = item.code_byte;
    cmd.done    = finished_next;
    cmd.npix    = '0;
    if (!fin_e) begin
      unique case (ph_e)
        PH_RUN:     cmd.npix = run_w;
        PH_LITERAL: cmd.npix = RUN_W'(1);
        default:    cmd.npix = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CONTROL;
      remaining <= '0;
      position  <= POS_W'(0);
      finished  <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      position  <= position_next;
      finished  <= finished_next;
    end
  end

endmodule

@@ sv/rgcd_cmd_queue.sv @@
// two-entry command queue between the byte parser and the pixel writer
// depends on rgcd_pkg
module rgcd_cmd_queue import rgcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic rd_valid
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) entry[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/rgcd_back.sv @@
// back end: expands commands into result beats of up to two pixel writes
// depends on rgcd_pkg
module rgcd_back import rgcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic [ROWS_W-1:0] glyph_rows,
  input  logic [ADDR_W-1:0] start_position,
  output out_item_t         result,
  output logic              empty,
  input  logic              pop
);

  logic             busy;
  logic [RUN_W-1:0] left;
  logic [7:0]       value;
  logic             done;
  pix_pos_t         pp;
  logic             res_valid;
  out_item_t        res;

  logic             free;
  logic             emit;
  pix_pos_t         pp1;
  pix_pos_t         pp2;
  logic [1:0]       n;
  logic             last_beat;
  out_item_t        res_next;

  assign free    = !res_valid || pop;
  assign emit    = busy && free;
  assign cmd_pop = !busy && cmd_valid;
  assign empty   = !res_valid;
  assign result  = res;

  always_comb begin
    pp1       = pos_inc(pp);
    pp2       = pos_inc(pp1);
    n         = (left >= RUN_W'(2)) ? 2'd2 : left[1:0];
    last_beat = (left <= RUN_W'(2));
    res_next  = '0;
    if (n != 2'd0) begin
      res_next.address_a = glyph_addr(pp, glyph_rows);
      res_next.value_a   = value;
    end
    if (n == 2'd2) begin
      res_next.address_b = glyph_addr(pp1, glyph_rows);
      res_next.value_b   = value;
    end
    res_next.pixel_count = n;
    res_next.last        = last_beat;
    res_next.done_res    = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp <= '0;
    end else if (cmd_pop) begin
      value <= cmd.value;
      done  <= cmd.done;
      if (cmd.restart) pp <= pos_split(start_position);
    end else if (emit) begin
      priority case (n)
        2'd2:    pp <= pp2;
        2'd1:    pp <= pp1;
        default: pp <= pp;
      endcase
    end
    if (emit) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      left      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy <= 1'b1;
        left <= cmd.npix;
      end else if (emit) begin
        busy <= !last_beat;
        left <= left - RUN_W'(n);
      end
      if (emit) res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.pixel_count != 2'd3)
    else $error("pixel count out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> res.pixel_count == 2'd2)
    else $error("short beat before end of byte");

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.pixel_count == 2'd0) |-> (res.address_a == '0 && res.value_a == '0))
    else $error("unused write slot not cleared");
`endif

endmodule

@@ sv/rle_glyph_column_decoder_top.sv @@
// rle glyph column decoder: one result beat per cycle while results are popped, each
// byte's command is loaded before its beats, which pass through the result register;
// a literal or control byte gives one beat, a run of k pixels ceil(k/2) (at least one)
// input rate is bounded by the pixel writer draining the two-entry command queue
// synchronous active-high reset clears parser, queue and output; rows 8, start 0
// depends on rgcd_pkg, rgcd_front, rgcd_cmd_queue, rgcd_back
module rle_glyph_column_decoder_top import rgcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_index_t  cfg_index,
  input  logic [11:0] cfg_data
);

  logic [ROWS_W-1:0] glyph_rows;
  logic [ADDR_W-1:0] start_position;
  logic              accept;
  cmd_t              front_cmd;
  cmd_t              queue_cmd;
  logic              queue_valid;
  logic              queue_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_rows     <= ROWS_W'(MAX_ROWS);
      start_position <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GLYPH_ROWS:     glyph_rows     <= cfg_data[ROWS_W-1:0];
        REG_START_POSITION: start_position <= cfg_data[ADDR_W-1:0];
        default:            glyph_rows     <= glyph_rows;
      endcase
    end
  end

  rgcd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .glyph_rows     (glyph_rows),
    .start_position (start_position),
    .cmd            (front_cmd)
  );

  rgcd_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_en    (queue_pop),
    .rd_data  (queue_cmd),
    .rd_valid (queue_valid)
  );

  rgcd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (queue_cmd),
    .cmd_valid      (queue_valid),
    .cmd_pop        (queue_pop),
    .glyph_rows     (glyph_rows),
    .start_position (start_position),
    .result         (result),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
